// File: rtl/esc_pkg.sv
// Shared widths, register codes and reset values for the encoder speed controller.
// No dependencies; imported by every module of the block.
package esc_pkg;

   localparam int DATA_W = 16;               // period, numerator, target, speed
   localparam int DUTY_W = 8;
   localparam int GAIN_W = 8;
   localparam int PHASE_W = 8;
   localparam int FRAC_W = 4;                // target is 12.4
   localparam int ERR_W = DATA_W + FRAC_W + 1;
   localparam int PROD_W = ERR_W + GAIN_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMERATOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDE = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd20;
   localparam logic [DATA_W-1:0] NUMERATOR_RESET = 16'd2000;
   localparam logic [PHASE_W-1:0] DIVIDE_RESET = 8'd8;

   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;

endpackage

// File: rtl/encoder_speed_p_controller.sv
// Encoder speed P controller: an edge word and a skipped overflow pass from accept through the
// done state to the result register; a control step runs a serial divider and then a serial
// multiplier before the done state. One word at a time; the next word is accepted while a
// finished result waits on rsp. Synchronous active-high reset clears period, phase,
// duty and speed to zero and restores gain 20, numerator 2000, divide 8.
module encoder_speed_p_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] edge_period, [31:16] target_speed
   input  logic        req_tuser,    // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] duty, [23:8] measured_speed
   output logic        rsp_tuser,    // [0] updated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [esc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [esc_pkg::DATA_W-1:0]    csr_data
);
   import esc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_MUL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [GAIN_W-1:0]  gain_ff;
   logic [DATA_W-1:0]  numer_ff;
   logic [PHASE_W-1:0] divide_ff;
   logic [DATA_W-1:0]  period_ff, period_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [DATA_W-1:0]  speed_ff, speed_in;
   logic [DATA_W-1:0]  target_ff, target_in;
   logic               upd_ff, upd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic               req_acc;
   logic               load_rsp;
   logic               div_start;
   logic               div_done;
   logic               mul_start;
   logic               mul_done;
   logic [DATA_W-1:0]  div_quo;
   logic [DATA_W-1:0]  divisor;
   logic [ERR_W-1:0]   err;
   logic [DUTY_W-1:0]  mul_duty;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // zero period divides as one
   assign divisor = (period_ff == '0) ? DATA_W'(1) : period_ff;
   assign err = ERR_W'(target_ff) - ERR_W'({div_quo, {FRAC_W{1'b0}}});

   assign div_start = req_acc && req_tuser && (phase_ff >= divide_ff);
   assign mul_start = div_done;

   esc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (numer_ff),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quo)
   );

   esc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .error (err),
      .gain  (gain_ff),
      .done  (mul_done),
      .duty  (mul_duty)
   );

   always_comb begin
      state_in = state_ff;
      period_in = period_ff;
      phase_in = phase_ff;
      duty_in = duty_ff;
      speed_in = speed_ff;
      target_in = target_ff;
      upd_in = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tvalid && rsp_tready)
         rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               target_in = req_tdata[31:16];
               upd_in = 1'b0;
               if (!req_tuser) begin
                  period_in = DATA_W'(({1'b0, period_ff} + {1'b0, req_tdata[15:0]}) >> 1);
                  state_in = ST_DONE;
               end else if (phase_ff >= divide_ff) begin
                  phase_in = '0;
                  state_in = ST_DIV;
               end else begin
                  phase_in = phase_ff + 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               speed_in = div_quo;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               duty_in = mul_duty;
               upd_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      upd_ff <= upd_in;
      if (load_rsp) begin
         rsp_data_ff <= {speed_ff, duty_ff};
         rsp_user_ff <= upd_ff;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         period_ff <= '0;
         phase_ff <= '0;
         duty_ff <= '0;
         speed_ff <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff <= GAIN_RESET;
         numer_ff <= NUMERATOR_RESET;
         divide_ff <= DIVIDE_RESET;
      end else begin
         state_ff <= state_in;
         period_ff <= period_in;
         phase_ff <= phase_in;
         duty_ff <= duty_in;
         speed_ff <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN:      gain_ff <= csr_data[GAIN_W-1:0];
               CSR_NUMERATOR: numer_ff <= csr_data;
               CSR_DIVIDE:    divide_ff <= csr_data[PHASE_W-1:0];
               default:       ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside the multiply state");

   a_edge_no_step: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_tuser) |=> (state_ff == ST_DONE && !upd_ff))
      else $error("edge word started a control step");

endmodule

// File: rtl/esc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on esc_pkg.
module esc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [esc_pkg::DATA_W-1:0] numerator,
   input  logic [esc_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [esc_pkg::DATA_W-1:0] quotient
);
   import esc_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;      // numerator bits shift out, quotient bits in
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = numerator;
         dvs_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/esc_mul.sv
// Shift-add multiplier, one gain bit per cycle, with duty clamp and truncation.
// Depends on esc_pkg.
module esc_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [esc_pkg::ERR_W-1:0]  error,     // signed 16.4 error
   input  logic [esc_pkg::GAIN_W-1:0] gain,
   output logic                       done,
   output logic [esc_pkg::DUTY_W-1:0] duty
);
   import esc_pkg::*;

   localparam int CNT_W = $clog2(GAIN_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);

   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] add_ff, add_in;
   logic [GAIN_W-1:0]        gsr_ff, gsr_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      add_in = add_ff;
      gsr_in = gsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         add_in = {{GAIN_W{error[ERR_W-1]}}, error};
         gsr_in = gain;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (gsr_ff[0])
            acc_in = acc_ff + add_ff;
         add_in = add_ff <<< 1;
         gsr_in = gsr_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      add_ff <= add_in;
      gsr_ff <= gsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // non-positive product gives zero, otherwise drop the fraction and saturate
   always_comb begin
      if (acc_ff[PROD_W-1] || acc_ff == '0)
         duty = '0;
      else if (|acc_ff[PROD_W-2:FRAC_W+DUTY_W])
         duty = DUTY_MAX;
      else
         duty = acc_ff[FRAC_W+DUTY_W-1:FRAC_W];
   end

   assign done = done_ff;

endmodule
